/* rtl/core/olb_pkg.sv */
`timescale 1ns / 1ps

package olb_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ID_BITS  = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KIND_W   = 3;

  typedef enum logic [KIND_W-1:0] {
    K_APPEND     = 3'd0,
    K_PREPEND    = 3'd1,
    K_REM_FIRST  = 3'd2,
    K_REM_LAST   = 3'd3,
    K_REMOVE     = 3'd4,
    K_CLEAR      = 3'd5,
    K_MOVE_END   = 3'd6,
    K_MOVE_BEGIN = 3'd7
  } kind_e;

  // what a cell takes at the next edge
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_LEFT  = 2'd2,
    OP_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp;
  } cell_cmd_t;

endpackage

/* rtl/core/olb_cell.sv */
`timescale 1ns / 1ps

module olb_cell (
  input  logic                       clk_i,
  input  olb_pkg::cell_cmd_t         cmd_i,
  input  logic [olb_pkg::ID_BITS-1:0] id_i,
  input  logic [olb_pkg::ID_BITS-1:0] left_i,
  input  logic [olb_pkg::ID_BITS-1:0] right_i,
  output logic [olb_pkg::ID_BITS-1:0] data_o,
  output logic                       eq_o
);
  import olb_pkg::*;

  logic [ID_BITS-1:0] data_q, data_d;
  logic               eq_q;

  always_comb begin
    case (cmd_i.op)
      OP_LOAD:  data_d = id_i;
      OP_LEFT:  data_d = left_i;
      OP_RIGHT: data_d = right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (cmd_i.cmp) begin
      eq_q <= (data_q == id_i);
    end
  end

  assign data_o = data_q;
  assign eq_o   = eq_q;

endmodule

/* rtl/core/ordered_block_list.sv */
`timescale 1ns / 1ps
// ordered list of block identifiers kept for replacement order, front first
// input channel: kind_i selects append, prepend, remove first, remove last,
// remove a given block, clear, move to end or move to begin; block_id_i is
// the identifier for the kinds that name one
// output channel: one result per transaction with the removed block, found
// flag, empty flag, entry count after the operation and an overflow flag
// the entries sit in a row of cells, each passing its identifier to a
// neighbour when the list shifts
// an accepted transaction passes the compare, first-match select and apply
// steps through the cell row in turn; the result is registered as the apply
// step ends, and a new transaction is taken only in the idle state after it
// reset empties the list; cell contents are left as they are
// when the receiver stalls the result stays in the output register; one more
// transaction is still taken and waits in its apply step, with in_ready_o
// low, until the held result is taken
module ordered_block_list (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [olb_pkg::KIND_W-1:0]   kind_i,
  input  logic [olb_pkg::ID_BITS-1:0]  block_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [olb_pkg::ID_BITS-1:0]  removed_block_o,
  output logic                         found_o,
  output logic                         is_empty_o,
  output logic [olb_pkg::CNT_W-1:0]    entry_count_o,
  output logic                         overflow_o
);
  import olb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_SEL   = 2'd2;
  localparam logic [1:0] ST_APPLY = 2'd3;

  logic [1:0]         state_q, state_d;
  kind_e              kind_q;
  logic [ID_BITS-1:0] id_q;
  logic [CNT_W-1:0]   len_q, len_d;

  cell_cmd_t          cmd       [CAPACITY];
  logic [ID_BITS-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] eq_vec, valid_vec, is_len, is_last, pick;
  logic [CAPACITY-1:0] eq_v, le_mask, low;
  logic [CAPACITY-1:0] ge_q, le_q;
  logic                any_q, eq0_q, last_hit_q;
  logic [ID_BITS-1:0]  rd_q, rd_d;

  logic               out_valid_q;
  logic [ID_BITS-1:0] removed_q;
  logic               found_q, ovf_q;

  logic in_acc, out_free, go;
  logic len_zero, len_full;
  logic f_shl_all, f_shl_ge, f_shr_all, f_shr_le, f_load0, f_load_len, f_load_last;
  logic res_found, res_ovf;
  logic [ID_BITS-1:0] res_removed;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign go         = (state_q == ST_APPLY) && out_free;
  assign len_zero   = (len_q == '0);
  assign len_full   = (len_q == CNT_W'(CAPACITY));

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ID_BITS-1:0] left_data, right_data;
    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end

    olb_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd[g]),
      .id_i    (id_q),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[g]),
      .eq_o    (eq_vec[g])
    );

    assign valid_vec[g] = CNT_W'(g) < len_q;
    assign is_len[g]    = CNT_W'(g) == len_q;
    assign is_last[g]   = CNT_W'(g + 1) == len_q;
  end

  // first match: bits up to and including the lowest set bit
  assign eq_v    = eq_vec & valid_vec;
  assign le_mask = eq_v ^ (eq_v - 1'b1);
  assign low     = le_mask & eq_v;
  assign pick    = (kind_q == K_REM_FIRST) ? CAPACITY'(1) : is_last;

  always_comb begin
    rd_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_d = rd_d | (cell_data[i] & {ID_BITS{pick[i]}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_e'(kind_i);
      id_q   <= block_id_i;
    end
    if (state_q == ST_SEL) begin
      ge_q       <= ~le_mask | low;
      le_q       <= le_mask;
      any_q      <= |eq_v;
      eq0_q      <= eq_v[0];
      last_hit_q <= |(low & is_last);
      rd_q       <= rd_d;
    end
  end

  // operation decode for the apply step
  always_comb begin
    f_shl_all   = 1'b0;
    f_shl_ge    = 1'b0;
    f_shr_all   = 1'b0;
    f_shr_le    = 1'b0;
    f_load0     = 1'b0;
    f_load_len  = 1'b0;
    f_load_last = 1'b0;
    res_found   = 1'b0;
    res_ovf     = 1'b0;
    res_removed = '0;
    len_d       = len_q;
    case (kind_q)
      K_APPEND: begin
        if (len_full) begin
          res_ovf = 1'b1;
        end else begin
          f_load_len = 1'b1;
          len_d      = len_q + 1'b1;
        end
      end
      K_PREPEND: begin
        if (len_full) begin
          res_ovf = 1'b1;
        end else begin
          f_shr_all = 1'b1;
          f_load0   = 1'b1;
          len_d     = len_q + 1'b1;
        end
      end
      K_REM_FIRST: begin
        if (!len_zero) begin
          res_found   = 1'b1;
          res_removed = rd_q;
          f_shl_all   = 1'b1;
          len_d       = len_q - 1'b1;
        end
      end
      K_REM_LAST: begin
        if (!len_zero) begin
          res_found   = 1'b1;
          res_removed = rd_q;
          len_d       = len_q - 1'b1;
        end
      end
      K_REMOVE: begin
        if (any_q) begin
          res_found   = 1'b1;
          res_removed = id_q;
          f_shl_ge    = 1'b1;
          len_d       = len_q - 1'b1;
        end
      end
      K_CLEAR: begin
        len_d = '0;
      end
      K_MOVE_END: begin
        if (len_zero) begin
          f_load0 = 1'b1;
          len_d   = CNT_W'(1);
        end else if (any_q && !last_hit_q) begin
          f_shl_ge    = 1'b1;
          f_load_last = 1'b1;
        end
      end
      default: begin
        if (len_zero) begin
          f_load0 = 1'b1;
          len_d   = CNT_W'(1);
        end else if (eq0_q) begin
          // already at the front
        end else if (any_q) begin
          f_shr_le = 1'b1;
          f_load0  = 1'b1;
        end else if (len_full) begin
          res_ovf = 1'b1;
        end else begin
          f_shr_all = 1'b1;
          f_load0   = 1'b1;
          len_d     = len_q + 1'b1;
        end
      end
    endcase
  end

  // per-cell commands, later assignments win
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i].cmp = (state_q == ST_CMP);
      cmd[i].op  = OP_HOLD;
      if (go) begin
        if (f_shl_all || (f_shl_ge && ge_q[i])) begin
          cmd[i].op = OP_RIGHT;
        end
        if ((i > 0) && (f_shr_all || (f_shr_le && le_q[i]))) begin
          cmd[i].op = OP_LEFT;
        end
        if ((f_load0 && (i == 0)) || (f_load_len && is_len[i]) ||
            (f_load_last && is_last[i])) begin
          cmd[i].op = OP_LOAD;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CMP;
      ST_CMP:   state_d = ST_SEL;
      ST_SEL:   state_d = ST_APPLY;
      ST_APPLY: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (go) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      removed_q <= res_removed;
      found_q   <= res_found;
      ovf_q     <= res_ovf;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_block_o = removed_q;
  assign found_o         = found_q;
  assign is_empty_o      = (len_q == '0);
  assign entry_count_o   = len_q;
  assign overflow_o      = ovf_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> entry_count_o == CNT_W'(CAPACITY))
    else $error("overflow reported on a list that is not full");

  a_found_ovf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> !overflow_o)
    else $error("removal and overflow in one result");

  a_len_only_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_APPLY |=> $stable(len_q))
    else $error("entry count changed outside the apply step");

  a_accept_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CMP ##1 state_q == ST_SEL)
    else $error("operation sequence broken");

endmodule

/* tb/sv/tb_ordered_block_list.sv */
`timescale 1ns / 1ps

module tb_ordered_block_list;
  import olb_pkg::*;

  typedef struct packed {
    logic [ID_BITS-1:0] removed_block;
    logic               found;
    logic               is_empty;
    logic [CNT_W-1:0]   entry_count;
    logic               overflow;
  } list_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i      = '0;
  logic [ID_BITS-1:0]  block_id_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ID_BITS-1:0]  removed_block_o;
  logic                found_o;
  logic                is_empty_o;
  logic [CNT_W-1:0]    entry_count_o;
  logic                overflow_o;

  // shadow copy of the list, front first
  logic [ID_BITS-1:0]  shadow_blocks[$];
  list_result_t        list_results_q[$];
  int                  fail_count = 0;

  ordered_block_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .block_id_i      (block_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .removed_block_o (removed_block_o),
    .found_o         (found_o),
    .is_empty_o      (is_empty_o),
    .entry_count_o   (entry_count_o),
    .overflow_o      (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int find_block(logic [ID_BITS-1:0] id);
    for (int i = 0; i < shadow_blocks.size(); i++) begin
      if (shadow_blocks[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic list_result_t apply_list_op(kind_e k, logic [ID_BITS-1:0] id);
    list_result_t r;
    int           pos;
    r = '0;
    case (k)
      K_APPEND: begin
        if (shadow_blocks.size() >= CAPACITY) r.overflow = 1'b1;
        else shadow_blocks.push_back(id);
      end
      K_PREPEND: begin
        if (shadow_blocks.size() >= CAPACITY) r.overflow = 1'b1;
        else shadow_blocks.push_front(id);
      end
      K_REM_FIRST: begin
        if (shadow_blocks.size() > 0) begin
          r.removed_block = shadow_blocks.pop_front();
          r.found = 1'b1;
        end
      end
      K_REM_LAST: begin
        if (shadow_blocks.size() > 0) begin
          r.removed_block = shadow_blocks.pop_back();
          r.found = 1'b1;
        end
      end
      K_REMOVE: begin
        pos = find_block(id);
        if (pos >= 0) begin
          r.removed_block = shadow_blocks[pos];
          r.found = 1'b1;
          shadow_blocks.delete(pos);
        end
      end
      K_CLEAR: shadow_blocks.delete();
      K_MOVE_END: begin
        if (shadow_blocks.size() == 0) begin
          shadow_blocks.push_back(id);
        end else begin
          pos = find_block(id);
          // absent or already last: left alone
          if (pos >= 0 && pos + 1 < shadow_blocks.size()) begin
            shadow_blocks.delete(pos);
            shadow_blocks.push_back(id);
          end
        end
      end
      default: begin
        if (shadow_blocks.size() == 0) begin
          shadow_blocks.push_front(id);
        end else if (shadow_blocks[0] != id) begin
          pos = find_block(id);
          if (pos >= 0) begin
            shadow_blocks.delete(pos);
            shadow_blocks.push_front(id);
          end else if (shadow_blocks.size() >= CAPACITY) begin
            r.overflow = 1'b1;
          end else begin
            shadow_blocks.push_front(id);
          end
        end
      end
    endcase
    r.is_empty    = (shadow_blocks.size() == 0);
    r.entry_count = CNT_W'(shadow_blocks.size());
    return r;
  endfunction

  // called at a rising edge, returns at the edge that accepts the transaction
  task automatic send_op(kind_e k, logic [ID_BITS-1:0] id);
    in_valid_i <= 1'b1;
    kind_i     <= k;
    block_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    list_results_q.push_back(apply_list_op(k, id));
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (list_results_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: ready pattern changes mode every so often
  int ready_mode = 0;
  int mode_left  = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= ($urandom_range(0, 7) != 0);
      default: out_ready_i <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (list_results_q.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        want = list_results_q.pop_front();
        if (removed_block_o !== want.removed_block) begin
          $error("removed_block: expected %0h, got %0h", want.removed_block, removed_block_o);
          fail_count++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found_o);
          fail_count++;
        end
        if (is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty_o);
          fail_count++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
          fail_count++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, overflow_o);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_list();
    send_op(K_REM_FIRST, 8'h00);
    send_op(K_REM_LAST, 8'hff);
    send_op(K_REMOVE, 8'h55);
    send_op(K_MOVE_END, 8'haa);
    send_op(K_REM_LAST, 8'h00);
    send_op(K_MOVE_BEGIN, 8'h00);
    send_op(K_REM_FIRST, 8'h00);
    send_op(K_CLEAR, 8'h00);
  endtask

  task automatic test_order_and_search();
    send_op(K_APPEND, 8'h00);
    send_op(K_APPEND, 8'hff);
    send_op(K_PREPEND, 8'h12);
    send_op(K_APPEND, 8'h12);
    // duplicate present: first occurrence from the front goes
    send_op(K_REMOVE, 8'h12);
    send_op(K_MOVE_END, 8'h12);
    send_op(K_MOVE_END, 8'h77);
    send_op(K_MOVE_END, 8'h00);
    send_op(K_MOVE_BEGIN, 8'hff);
    send_op(K_MOVE_BEGIN, 8'h00);
    send_op(K_MOVE_BEGIN, 8'h3c);
    send_op(K_REMOVE, 8'h99);
    send_op(K_REM_LAST, 8'h00);
    send_op(K_REM_FIRST, 8'h00);
    send_op(K_CLEAR, 8'h00);
    send_op(K_REM_LAST, 8'h00);
    wait_drained();
  endtask

  task automatic test_full_list();
    for (int i = 0; i < CAPACITY; i++) begin
      send_op(K_APPEND, ID_BITS'($urandom_range(0, 127)));
    end
    // inserts on a full list are dropped
    send_op(K_APPEND, 8'hc8);
    send_op(K_PREPEND, 8'hc9);
    send_op(K_MOVE_BEGIN, 8'hca);
    send_op(K_MOVE_BEGIN, shadow_blocks[CAPACITY/2]);
    send_op(K_MOVE_END, shadow_blocks[0]);
    send_op(K_REMOVE, shadow_blocks[5]);
    send_op(K_PREPEND, 8'hff);
    send_op(K_MOVE_BEGIN, 8'hcb);
    send_op(K_REM_LAST, 8'h00);
    send_op(K_MOVE_BEGIN, 8'hcc);
    send_op(K_CLEAR, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_ops(int n_items);
    logic [ID_BITS-1:0] id_pool[8];
    logic [ID_BITS-1:0] id;
    kind_e              k;
    int                 burst_left;
    int                 insert_pct;
    int                 r;
    burst_left = 0;
    insert_pct = 70;
    foreach (id_pool[j]) id_pool[j] = ID_BITS'($urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) insert_pct = ((i / 100) % 2 == 0) ? 75 : 25;
      if (i == n_items / 2) wait_drained();
      if (burst_left == 0) begin
        pause_sender($urandom_range(0, 6));
        burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
      end
      burst_left--;
      id = ($urandom_range(0, 3) == 0) ? ID_BITS'($urandom_range(0, 255))
                                       : id_pool[$urandom_range(0, 7)];
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) begin
        k = kind_e'($urandom_range(0, 7));
      end else if (r < insert_pct) begin
        case ($urandom_range(0, 2))
          0: k = K_APPEND;
          1: k = K_PREPEND;
          default: k = K_MOVE_BEGIN;
        endcase
      end else if ($urandom_range(0, 99) == 0) begin
        k = K_CLEAR;
      end else begin
        case ($urandom_range(0, 3))
          0: k = K_REM_FIRST;
          1: k = K_REM_LAST;
          2: k = K_REMOVE;
          default: k = K_MOVE_END;
        endcase
      end
      send_op(k, id);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_order_and_search();
    test_full_list();
    test_random_ops(800);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && list_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/olb_pkg.sv
rtl/core/olb_cell.sv
rtl/core/ordered_block_list.sv
tb/sv/tb_ordered_block_list.sv
